@@ hdl/gate_motor_controller_assert.svh @@
// Assertion macros for the gate motor controller.
`ifndef GATE_MOTOR_CONTROLLER_ASSERT_SVH
`define GATE_MOTOR_CONTROLLER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define GMC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define GMC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/gmc_pkg.sv @@
// Types and constants shared by the gate motor controller.
package gmc_pkg;

    localparam int CntWidth = 16;

    localparam logic [2:0] ST_INITIAL = 3'd0;
    localparam logic [2:0] ST_CLOSING = 3'd1;
    localparam logic [2:0] ST_OPENING = 3'd2;
    localparam logic [2:0] ST_CLOSED  = 3'd3;
    localparam logic [2:0] ST_OPEN    = 3'd4;
    localparam logic [2:0] ST_ERROR   = 3'd5;
    localparam logic [2:0] ST_STOP    = 3'd6;

    localparam logic [1:0] FAULT_NONE    = 2'd0;
    localparam logic [1:0] FAULT_OPENING = 2'd1;
    localparam logic [1:0] FAULT_CLOSING = 2'd2;

    localparam logic REG_RUN_LIMIT       = 1'b0;
    localparam logic REG_AUTOCLOSE_LIMIT = 1'b1;

    localparam logic [CntWidth-1:0] RUN_LIMIT_RESET       = 16'd180;
    localparam logic [CntWidth-1:0] AUTOCLOSE_LIMIT_RESET = 16'd100;

    typedef struct packed {
        logic limit_closed;
        logic limit_open;
        logic open_button;
        logic close_button;
        logic multi_button;
        logic emergency_stop;
    } gmc_in_t;

    typedef struct packed {
        logic       motor_open;
        logic       motor_close;
        logic       lamp;
        logic       buzzer;
        logic [2:0] gate_state;
        logic [1:0] fault_code;
    } gmc_out_t;

endpackage

@@ hdl/gate_motor_controller.sv @@
// Gate motor controller: seven-state gate sequencer with run and auto-close timers.
// Each input word is one tick of the controller and produces one result word. The
// block takes a word in every cycle while the output side does not stall: a word is
// held in the input register, the state update and result are computed from it in
// one pass of compare and increment logic, and the result lands in the output
// register. run_limit (address 0) and autoclose_limit (address 4) are written over
// the APB port, only while no word is in flight; the user must ensure this, as the
// block does not enforce it. Reset values are 180 and 100 ticks.
module gate_motor_controller
    import gmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  gmc_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output gmc_out_t    out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CntWidth-1:0] run_lim_reg;
    logic [CntWidth-1:0] auto_lim_reg;

    logic          in_valid_reg;
    gmc_in_t       in_data_reg;
    logic          out_valid_reg;
    gmc_out_t      out_data_reg;

    logic [2:0]          state_reg, state_next;
    logic [CntWidth-1:0] run_count_reg, run_count_next;
    logic [CntWidth-1:0] open_count_reg, open_count_next;
    logic [1:0]          fault_reg, fault_next;
    logic                buzzer_reg, buzzer_next;
    logic [1:0]          blink_reg, blink_next;
    gmc_out_t            result;

    logic load;
    logic advance;
    logic cfg_write;
    logic [CntWidth-1:0] run_inc;
    logic [CntWidth-1:0] open_inc;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_AUTOCLOSE_LIMIT)
        begin
            prdata[CntWidth-1:0] = auto_lim_reg;
        end
        else
        begin
            prdata[CntWidth-1:0] = run_lim_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_lim_reg  <= RUN_LIMIT_RESET;
            auto_lim_reg <= AUTOCLOSE_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_RUN_LIMIT)
            begin
                run_lim_reg <= pwdata[CntWidth-1:0];
            end
            else
            begin
                auto_lim_reg <= pwdata[CntWidth-1:0];
            end
        end
    end

    // ---------------- handshake ----------------
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- controller ----------------
    assign run_inc  = (run_count_reg == '1) ? run_count_reg : run_count_reg + 1'b1;
    assign open_inc = (open_count_reg == '1) ? open_count_reg : open_count_reg + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        run_count_next  = run_count_reg;
        open_count_next = open_count_reg;
        fault_next      = fault_reg;
        buzzer_next     = buzzer_reg;
        blink_next      = blink_reg;

        unique case (state_reg)
            ST_CLOSING:
            begin
                run_count_next = run_inc;
                if (in_data_reg.limit_closed)
                begin
                    state_next = ST_CLOSED;
                end
                else if (run_inc > run_lim_reg)
                begin
                    fault_next = FAULT_CLOSING;
                    state_next = ST_ERROR;
                end
                else if (in_data_reg.open_button || in_data_reg.multi_button ||
                         in_data_reg.emergency_stop)
                begin
                    state_next = ST_STOP;
                end
            end
            ST_OPENING:
            begin
                run_count_next = run_inc;
                if (in_data_reg.limit_open)
                begin
                    state_next = ST_OPEN;
                end
                else if (run_inc > run_lim_reg)
                begin
                    fault_next = FAULT_OPENING;
                    state_next = ST_ERROR;
                end
                else if (in_data_reg.close_button || in_data_reg.multi_button ||
                         in_data_reg.emergency_stop)
                begin
                    state_next = ST_STOP;
                end
            end
            ST_CLOSED:
            begin
                if (in_data_reg.open_button || in_data_reg.multi_button)
                begin
                    state_next = ST_OPENING;
                end
                else if (in_data_reg.emergency_stop)
                begin
                    state_next = ST_STOP;
                end
            end
            ST_OPEN:
            begin
                open_count_next = open_inc;
                if ((open_inc > auto_lim_reg) || in_data_reg.close_button ||
                    in_data_reg.multi_button)
                begin
                    state_next = ST_CLOSING;
                end
                else if (in_data_reg.emergency_stop)
                begin
                    state_next = ST_STOP;
                end
            end
            ST_ERROR, ST_STOP:
            begin
                if (!in_data_reg.emergency_stop)
                begin
                    state_next = ST_INITIAL;
                end
            end
            default:
            begin
                if (in_data_reg.emergency_stop)
                begin
                    state_next = ST_STOP;
                end
                else if (in_data_reg.limit_closed && in_data_reg.limit_open)
                begin
                    state_next = ST_ERROR;
                end
                else if (in_data_reg.limit_closed)
                begin
                    state_next = ST_CLOSED;
                end
                else if (in_data_reg.limit_open)
                begin
                    state_next = ST_OPEN;
                end
                else
                begin
                    state_next = ST_CLOSING;
                end
            end
        endcase

        // Apply entry actions, or advance the blink phase while still moving.
        if (state_next != state_reg)
        begin
            if (state_next == ST_CLOSING || state_next == ST_OPENING)
            begin
                run_count_next = '0;
                blink_next     = '0;
            end
            else if (state_next == ST_OPEN)
            begin
                open_count_next = '0;
            end
            else if (state_next == ST_ERROR)
            begin
                buzzer_next = 1'b1;
            end
            else if (state_next == ST_STOP)
            begin
                buzzer_next = 1'b0;
            end
        end
        else if (state_reg == ST_CLOSING || state_reg == ST_OPENING)
        begin
            blink_next = blink_reg + 1'b1;
        end

        result.motor_open  = (state_next == ST_OPENING);
        result.motor_close = (state_next == ST_CLOSING);
        result.buzzer      = buzzer_next;
        result.gate_state  = state_next;
        result.fault_code  = fault_next;
        if (state_next == ST_OPENING)
        begin
            result.lamp = !blink_next[1];
        end
        else if (state_next == ST_CLOSING)
        begin
            result.lamp = !blink_next[0];
        end
        else
        begin
            result.lamp = (state_next == ST_OPEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INITIAL;
            run_count_reg  <= '0;
            open_count_reg <= '0;
            fault_reg      <= FAULT_NONE;
            buzzer_reg     <= 1'b0;
            blink_reg      <= '0;
        end
        else if (advance)
        begin
            state_reg      <= state_next;
            run_count_reg  <= run_count_next;
            open_count_reg <= open_count_next;
            fault_reg      <= fault_next;
            buzzer_reg     <= buzzer_next;
            blink_reg      <= blink_next;
        end
    end

    // ---------------- assertions ----------------
    `include "gate_motor_controller_assert.svh"

    `GMC_ASSERT_IMP(a_state_out, out_valid, out_data.gate_state == state_reg, "state drift")
    `GMC_ASSERT_IMP(a_motor, out_valid && out_data.motor_open, !out_data.motor_close, "motor clash")
    `GMC_ASSERT(a_fault_legal, fault_reg != 2'b11, "illegal fault code held")
    `GMC_ASSERT_IMP(a_buzzer_error, state_reg == ST_ERROR, buzzer_reg, "buzzer off in error")

endmodule
